[rtl/etfp_pkg.sv]
// shared types, constants and helpers for the escape-time fractal pixel unit
// no dependencies
package etfp_pkg;

  localparam int unsigned PIX_W      = 10;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned Q_W        = 32;
  localparam int unsigned STEP_W     = 31;
  localparam int unsigned PROD_W     = PIX_W + STEP_W;
  localparam int unsigned SQ_W       = 2 * Q_W;
  localparam int unsigned SAT_IN_W   = PROD_W + 2;
  localparam int unsigned TENX_W     = CNT_W + 4;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned FRAC_SH    = 28;
  localparam int unsigned CROSS_SH   = 27;

  localparam int unsigned DEF_WIDTH  = 1024;
  localparam int unsigned DEF_HEIGHT = 1024;

  // |z|^2 bound of 4.0 in Q8.56
  localparam logic [SQ_W-1:0] ESCAPE_BOUND = SQ_W'(64'h0400_0000_0000_0000);

  typedef enum logic [2:0] {
    REG_START_REAL = 3'd0,
    REG_START_IMAG = 3'd1,
    REG_LEFT_X     = 3'd2,
    REG_TOP_Y      = 3'd3,
    REG_STEP_X     = 3'd4,
    REG_STEP_Y     = 3'd5,
    REG_ITER_LIMIT = 3'd6,
    REG_INTERIOR   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] column;
    logic [PIX_W-1:0] row;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_column;
    logic [PIX_W-1:0] out_row;
    logic [CNT_W-1:0] iteration_count;
    logic             draw;
  } pixel_out_t;

  typedef struct packed {
    logic signed [Q_W-1:0] start_real;
    logic signed [Q_W-1:0] start_imag;
    logic signed [Q_W-1:0] left_x;
    logic signed [Q_W-1:0] top_y;
    logic [STEP_W-1:0]     step_x;
    logic [STEP_W-1:0]     step_y;
    logic [CNT_W-1:0]      iteration_limit;
    logic                  interior_mode;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic origin;
    logic square;
    logic step;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic finish;
  } dp_status_t;

  // clamp a wide signed value to the q4.28 range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_IN_W-1:0] v);
    logic hi_any;
    logic hi_all;
    logic signed [Q_W-1:0] res;
    hi_any = |v[SAT_IN_W-2:Q_W-1];
    hi_all = &v[SAT_IN_W-2:Q_W-1];
    if (!v[SAT_IN_W-1] && hi_any) begin
      res = {1'b0, {(Q_W-1){1'b1}}};
    end else if (v[SAT_IN_W-1] && !hi_all) begin
      res = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      res = v[Q_W-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/etfp_cfg_regs.sv]
// configuration register file behind the apb-style port
// depends on etfp_pkg
module etfp_cfg_regs import etfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t     regs_r;
  cfg_t     regs_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (idx)
        REG_START_REAL: regs_nxt.start_real      = cfg_pwdata[Q_W-1:0];
        REG_START_IMAG: regs_nxt.start_imag      = cfg_pwdata[Q_W-1:0];
        REG_LEFT_X:     regs_nxt.left_x          = cfg_pwdata[Q_W-1:0];
        REG_TOP_Y:      regs_nxt.top_y           = cfg_pwdata[Q_W-1:0];
        REG_STEP_X:     regs_nxt.step_x          = cfg_pwdata[STEP_W-1:0];
        REG_STEP_Y:     regs_nxt.step_y          = cfg_pwdata[STEP_W-1:0];
        REG_ITER_LIMIT: regs_nxt.iteration_limit = cfg_pwdata[CNT_W-1:0];
        REG_INTERIOR:   regs_nxt.interior_mode   = cfg_pwdata[0];
        default:        regs_nxt = regs_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_REAL: cfg_prdata = regs_r.start_real;
      REG_START_IMAG: cfg_prdata = regs_r.start_imag;
      REG_LEFT_X:     cfg_prdata = regs_r.left_x;
      REG_TOP_Y:      cfg_prdata = regs_r.top_y;
      REG_STEP_X:     cfg_prdata = CFG_DATA_W'(regs_r.step_x);
      REG_STEP_Y:     cfg_prdata = CFG_DATA_W'(regs_r.step_y);
      REG_ITER_LIMIT: cfg_prdata = CFG_DATA_W'(regs_r.iteration_limit);
      REG_INTERIOR:   cfg_prdata = CFG_DATA_W'(regs_r.interior_mode);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.start_real      <= '0;
      regs_r.start_imag      <= '0;
      regs_r.left_x          <= Q_W'(32'hE000_0000);
      regs_r.top_y           <= Q_W'(32'h2000_0000);
      regs_r.step_x          <= STEP_W'(1048576);
      regs_r.step_y          <= STEP_W'(1048576);
      regs_r.iteration_limit <= CNT_W'(100);
      regs_r.interior_mode   <= 1'b1;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

[rtl/etfp_datapath.sv]
// coordinate, iteration and selection datapath of the fractal pixel unit
// depends on etfp_pkg; driven by etfp_ctrl commands
module etfp_datapath import etfp_pkg::*; #(
  parameter int unsigned WIDTH  = DEF_WIDTH,
  parameter int unsigned HEIGHT = DEF_HEIGHT
) (
  input  logic       clk,
  input  cfg_t       cfg,
  input  pixel_in_t  in_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output pixel_out_t out_data
);

  pixel_in_t              pix_r;
  logic [PROD_W-1:0]      prod_x_r, prod_x_nxt;
  logic [PROD_W-1:0]      prod_y_r, prod_y_nxt;
  logic signed [Q_W-1:0]  cr_r, cr_nxt;
  logic signed [Q_W-1:0]  ci_r, ci_nxt;
  logic signed [Q_W-1:0]  zr_r, zr_nxt;
  logic signed [Q_W-1:0]  zi_r, zi_nxt;
  logic signed [SQ_W-1:0] rr_r, rr_nxt;
  logic signed [SQ_W-1:0] ii_r, ii_nxt;
  logic signed [SQ_W-1:0] ri_r, ri_nxt;
  logic [CNT_W-1:0]       count_r;
  pixel_out_t             res_r, res_nxt;

  logic signed [SQ_W-1:0]     diff;
  logic signed [SQ_W-1:0]     diff_sh;
  logic signed [SQ_W-1:0]     cross_sh;
  logic signed [SAT_IN_W-1:0] nr_sum;
  logic signed [SAT_IN_W-1:0] ni_sum;
  logic [SQ_W-1:0]            mag;
  logic                       escaped;
  logic                       limit_hit;
  logic [TENX_W-1:0]          tenx;
  logic                       in_window;
  logic                       draw_nxt;

  assign prod_x_nxt = PROD_W'(in_data.column) * PROD_W'(cfg.step_x);
  assign prod_y_nxt = PROD_W'(in_data.row) * PROD_W'(cfg.step_y);

  assign cr_nxt = sat_q(SAT_IN_W'(cfg.left_x) + $signed(SAT_IN_W'(prod_x_r)));
  assign ci_nxt = sat_q(SAT_IN_W'(cfg.top_y) - $signed(SAT_IN_W'(prod_y_r)));

  assign rr_nxt = SQ_W'(zr_r) * SQ_W'(zr_r);
  assign ii_nxt = SQ_W'(zi_r) * SQ_W'(zi_r);
  assign ri_nxt = SQ_W'(zr_r) * SQ_W'(zi_r);

  // floor shift back to q4.28, doubled cross term
  assign diff     = rr_r - ii_r;
  assign diff_sh  = diff >>> FRAC_SH;
  assign cross_sh = ri_r >>> CROSS_SH;
  assign nr_sum   = SAT_IN_W'(diff_sh) + SAT_IN_W'(cr_r);
  assign ni_sum   = SAT_IN_W'(cross_sh) + SAT_IN_W'(ci_r);
  assign zr_nxt   = sat_q(nr_sum);
  assign zi_nxt   = sat_q(ni_sum);

  assign mag       = $unsigned(rr_r) + $unsigned(ii_r);
  assign escaped   = mag >= ESCAPE_BOUND;
  assign limit_hit = count_r >= cfg.iteration_limit;
  assign status.finish = escaped || limit_hit;

  assign tenx = {1'b0, count_r, 3'b000} + {3'b000, count_r, 1'b0};
  assign in_window = (DIM_W'(pix_r.column) < DIM_W'(WIDTH)) &&
                     (DIM_W'(pix_r.row) < DIM_W'(HEIGHT));

  always_comb begin
    if (cfg.interior_mode) begin
      draw_nxt = count_r == cfg.iteration_limit;
    end else begin
      draw_nxt = (tenx > TENX_W'(cfg.iteration_limit)) && (count_r < cfg.iteration_limit);
    end
    res_nxt.out_column      = pix_r.column;
    res_nxt.out_row         = pix_r.row;
    res_nxt.iteration_count = count_r;
    res_nxt.draw            = draw_nxt && in_window;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r    <= in_data;
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      zr_r     <= cfg.start_real;
      zi_r     <= cfg.start_imag;
      count_r  <= '0;
    end
    if (cmd.origin) begin
      cr_r <= cr_nxt;
      ci_r <= ci_nxt;
    end
    if (cmd.square) begin
      rr_r <= rr_nxt;
      ii_r <= ii_nxt;
      ri_r <= ri_nxt;
    end
    if (cmd.step) begin
      zr_r    <= zr_nxt;
      zi_r    <= zi_nxt;
      count_r <= count_r + CNT_W'(1);
    end
    if (cmd.publish) begin
      res_r <= res_nxt;
    end
  end

  assign out_data = res_r;

endmodule

[rtl/etfp_ctrl.sv]
// sequencing state machine and output handshake of the fractal pixel unit
// depends on etfp_pkg; commands etfp_datapath
module etfp_ctrl import etfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ORIGIN,
    S_SQUARE,
    S_STEP,
    S_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ORIGIN;
        end
      end
      S_ORIGIN: begin
        cmd.origin = 1'b1;
        state_nxt  = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = S_STEP;
      end
      S_STEP: begin
        if (!status.finish) begin
          cmd.step  = 1'b1;
          state_nxt = S_SQUARE;
        end else if (out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.publish || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/escape_time_fractal_pixel_unit.sv]
// top level of the escape-time fractal pixel unit
// depends on etfp_pkg, etfp_cfg_regs, etfp_ctrl and etfp_datapath
//
// usage:
// - input channel (in_valid, in_stall, in_data) carries one pixel (column, row)
//   per transaction; the output channel (out_valid, out_stall, out_data) returns
//   one transaction per pixel with its position, iteration count and draw flag
// - the apb-style cfg_ port holds the start point, window origin and steps,
//   iteration limit and draw mode; write it only while no pixel is in flight
// - one pixel is processed at a time; each iteration of z = z*z + c has two
//   steps (product registers, then update and escape test)
// - in_stall is high from acceptance until the result is loaded into the
//   output register; the next pixel is taken the cycle after that, even while
//   the previous result still waits on out_stall
// - a result that cannot be handed over waits in the datapath, with the
//   controller holding, until the output register frees up
// - synchronous reset returns the controller to idle, drops out_valid and
//   restores the register defaults; no clearing pass is needed
module escape_time_fractal_pixel_unit import etfp_pkg::*; #(
  parameter int unsigned WIDTH  = DEF_WIDTH,
  parameter int unsigned HEIGHT = DEF_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pixel_in_t             in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pixel_out_t            out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  etfp_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  etfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  etfp_datapath #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_datapath (
    .clk      (clk),
    .cfg      (cfg),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
